>>> design/cdi_pkg.sv
package cdi_pkg;

   localparam int unsigned DayWidth = 5;
   localparam int unsigned MonthWidth = 4;
   localparam int unsigned YearWidth = 14;
   localparam int unsigned DoyWidth = 9;
   localparam int unsigned WeekdayWidth = 3;
   localparam int unsigned WeekWidth = 6;

   // reciprocal constants for the constant divisions
   localparam int unsigned Div100Mult = 5243;
   localparam int unsigned Div100Shift = 19;
   localparam int unsigned Div7WideMult = 18725;
   localparam int unsigned Div7WideShift = 17;
   localparam int unsigned Div7NarrowMult = 293;
   localparam int unsigned Div7NarrowShift = 11;

   localparam logic [MonthWidth-1:0] MonthJan = 4'd1;
   localparam logic [MonthWidth-1:0] MonthFeb = 4'd2;
   localparam logic [MonthWidth-1:0] MonthDec = 4'd12;

   typedef struct packed {
      logic [DayWidth-1:0]   day;
      logic [MonthWidth-1:0] month;
      logic [YearWidth-1:0]  year;
      logic [YearWidth-1:0]  zyear;
      logic [7:0]            year_div100;
      logic [7:0]            zyear_div100;
      logic [5:0]            month_term;
      logic [DoyWidth-1:0]   days_before;
      logic [4:0]            month_len;
   } stage1_type;

   typedef struct packed {
      logic                ok;
      logic                leap;
      logic [DoyWidth-1:0] day_of_year;
      logic [15:0]         zeller_sum;
   } stage2_type;

   // non-leap month length, 0 for a month number out of range
   function automatic logic [4:0] month_length(input logic [MonthWidth-1:0] m);
      logic [4:0] len;
      case (m)
         4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
         4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
         4'd2: len = 5'd28;
         default: len = 5'd0;
      endcase
      return len;
   endfunction

   // days in the months before m, non-leap
   function automatic logic [DoyWidth-1:0] days_before_month(input logic [MonthWidth-1:0] m);
      logic [DoyWidth-1:0] cum;
      case (m)
         4'd2: cum = 9'd31;
         4'd3: cum = 9'd59;
         4'd4: cum = 9'd90;
         4'd5: cum = 9'd120;
         4'd6: cum = 9'd151;
         4'd7: cum = 9'd181;
         4'd8: cum = 9'd212;
         4'd9: cum = 9'd243;
         4'd10: cum = 9'd273;
         4'd11: cum = 9'd304;
         4'd12: cum = 9'd334;
         default: cum = 9'd0;
      endcase
      return cum;
   endfunction

   // floor(13 * (mm + 1) / 5), january and february as months 13 and 14
   function automatic logic [5:0] zeller_month_term(input logic [MonthWidth-1:0] m);
      logic [5:0] t;
      case (m)
         4'd1: t = 6'd36;
         4'd2: t = 6'd39;
         4'd3: t = 6'd10;
         4'd4: t = 6'd13;
         4'd5: t = 6'd15;
         4'd6: t = 6'd18;
         4'd7: t = 6'd20;
         4'd8: t = 6'd23;
         4'd9: t = 6'd26;
         4'd10: t = 6'd28;
         4'd11: t = 6'd31;
         4'd12: t = 6'd33;
         default: t = 6'd0;
      endcase
      return t;
   endfunction

endpackage

>>> design/cdi_ifs.sv
interface cdi_req_if import cdi_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [DayWidth-1:0]   day;
   logic [MonthWidth-1:0] month;
   logic [YearWidth-1:0]  year;

   modport source (output valid, output day, output month, output year, input ready);
   modport sink (input valid, input day, input month, input year, output ready);
endinterface

interface cdi_rsp_if import cdi_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic                    valid_res;
   logic                    leap;
   logic [DoyWidth-1:0]     day_of_year;
   logic [WeekdayWidth-1:0] weekday;
   logic [WeekWidth-1:0]    week_number;

   modport source (output valid, output valid_res, output leap, output day_of_year,
                   output weekday, output week_number, input ready);
   modport sink (input valid, input valid_res, input leap, input day_of_year,
                 input weekday, input week_number, output ready);
endinterface

>>> design/calendar_date_info_core.sv
// Gregorian date information: each transfer on req_chan carries a day, month and year, and
// gives one transfer on rsp_chan with a validity flag, the leap-year flag (computed even for
// an invalid date), the ordinal day of the year, the weekday by Zeller's congruence with
// 0 = Sunday, and a simple week number (day of year / 7 + 1, not ISO). For an invalid date
// the day of year, weekday and week number are 0. The block is a three-stage pipeline
// (table lookup and divide-by-100 multiplies, leap and sums, divide-by-7 and output
// register): a date can be accepted every cycle while rsp_chan is not stalled, and each
// result passes through the stage-1, stage-2 and output registers before it appears.
module calendar_date_info_core import cdi_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   cdi_req_if.sink   req_chan,
   cdi_rsp_if.source rsp_chan
);

   logic       v1_ff, v1_in, v2_ff, v2_in, v3_ff, v3_in;
   logic       rdy1, rdy2, rdy3;
   stage1_type s1_ff, s1_in;
   stage2_type s2_ff, s2_in;

   logic                    valid_res_ff, valid_res_in;
   logic                    leap_ff, leap_in;
   logic [DoyWidth-1:0]     doy_ff, doy_in;
   logic [WeekdayWidth-1:0] wd_ff, wd_in;
   logic [WeekWidth-1:0]    wk_ff, wk_in;

   assign rdy3 = !v3_ff || rsp_chan.ready;
   assign rdy2 = !v2_ff || rdy3;
   assign rdy1 = !v1_ff || rdy2;
   assign req_chan.ready = rdy1;

   assign v1_in = rdy1 ? req_chan.valid : v1_ff;
   assign v2_in = rdy2 ? v1_ff : v2_ff;
   assign v3_in = rdy3 ? v2_ff : v3_ff;

   // stage 1: month tables and divide by 100
   logic [YearWidth-1:0] zyear;
   logic [26:0]          y_prod, zy_prod;

   always_comb begin
      zyear = (req_chan.month <= MonthFeb) ? req_chan.year - 14'd1 : req_chan.year;
      y_prod = 27'(req_chan.year) * 27'(Div100Mult);
      zy_prod = 27'(zyear) * 27'(Div100Mult);
      s1_in.day = req_chan.day;
      s1_in.month = req_chan.month;
      s1_in.year = req_chan.year;
      s1_in.zyear = zyear;
      s1_in.year_div100 = y_prod[Div100Shift +: 8];
      s1_in.zyear_div100 = zy_prod[Div100Shift +: 8];
      s1_in.month_term = zeller_month_term(req_chan.month);
      s1_in.days_before = days_before_month(req_chan.month);
      s1_in.month_len = month_length(req_chan.month);
   end

   // stage 2: leap flag, validity, day of year, zeller sum
   logic [14:0] hundreds;
   logic        div100;
   logic        leap;
   logic        feb;
   logic [4:0]  len;

   always_comb begin
      hundreds = 15'(s1_ff.year_div100) * 15'd100;
      div100 = (hundreds == {1'b0, s1_ff.year});
      leap = (s1_ff.year[1:0] == 2'd0 && !div100) ||
             (div100 && s1_ff.year_div100[1:0] == 2'd0);
      feb = (s1_ff.month == MonthFeb);
      len = s1_ff.month_len + {4'd0, leap && feb};
      s2_in.leap = leap;
      s2_in.ok = (s1_ff.month_len != 5'd0) && (s1_ff.day != 5'd0) &&
                 (s1_ff.day <= len) && (s1_ff.year != 14'd0);
      s2_in.day_of_year = s1_ff.days_before + 9'(s1_ff.day) +
                          9'(leap && s1_ff.month > MonthFeb);
      s2_in.zeller_sum = 16'(s1_ff.day) + 16'(s1_ff.month_term) + 16'(s1_ff.zyear) +
                         16'(s1_ff.zyear >> 2) + 16'(s1_ff.zyear_div100 >> 2) -
                         16'(s1_ff.zyear_div100);
   end

   // stage 3: mod 7 and week number
   logic [15:0] hx;
   logic [31:0] hq_prod;
   logic [13:0] hq;
   logic [15:0] hq7;
   logic [17:0] dq_prod;
   logic [6:0]  dq;

   always_comb begin
      hx = s2_ff.zeller_sum + 16'd6;
      hq_prod = 32'(hx) * 32'(Div7WideMult);
      hq = hq_prod[Div7WideShift +: 14];
      hq7 = 16'(hq) * 16'd7;
      dq_prod = 18'(s2_ff.day_of_year) * 18'(Div7NarrowMult);
      dq = dq_prod[Div7NarrowShift +: 7];
      valid_res_in = s2_ff.ok;
      leap_in = s2_ff.leap;
      doy_in = s2_ff.ok ? s2_ff.day_of_year : '0;
      wd_in = s2_ff.ok ? 3'(hx - hq7) : '0;
      wk_in = s2_ff.ok ? 6'(dq) + 6'd1 : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
         v3_ff <= v3_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy1 && req_chan.valid) begin
         s1_ff <= s1_in;
      end
      if (rdy2 && v1_ff) begin
         s2_ff <= s2_in;
      end
      if (rdy3 && v2_ff) begin
         valid_res_ff <= valid_res_in;
         leap_ff <= leap_in;
         doy_ff <= doy_in;
         wd_ff <= wd_in;
         wk_ff <= wk_in;
      end
   end

   assign rsp_chan.valid = v3_ff;
   assign rsp_chan.valid_res = valid_res_ff;
   assign rsp_chan.leap = leap_ff;
   assign rsp_chan.day_of_year = doy_ff;
   assign rsp_chan.weekday = wd_ff;
   assign rsp_chan.week_number = wk_ff;

`ifndef SYNTHESIS
   a_invalid_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && !rsp_chan.valid_res |->
         rsp_chan.day_of_year == 9'd0 && rsp_chan.weekday == 3'd0 &&
         rsp_chan.week_number == 6'd0)
      else $error("invalid date with nonzero fields");
   a_valid_ranges: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.valid_res |->
         rsp_chan.day_of_year != 9'd0 && rsp_chan.weekday <= 3'd6 &&
         rsp_chan.week_number != 6'd0)
      else $error("valid date with field out of range");
   a_nonleap_len: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.valid_res && !rsp_chan.leap |->
         rsp_chan.day_of_year <= 9'd365)
      else $error("day 366 in a common year");
`endif

endmodule

>>> bench/date_info_checker.sv
module date_info_checker import cdi_pkg::*; (
   input  logic clock,
   input  logic reset,
   cdi_req_if   req_mon,
   cdi_rsp_if   rsp_mon,
   output int   mismatches,
   output int   outstanding,
   output int   good_dates
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic                    valid_res;
      logic                    leap;
      logic [DoyWidth-1:0]     day_of_year;
      logic [WeekdayWidth-1:0] weekday;
      logic [WeekWidth-1:0]    week_number;
   } date_info_type;

   date_info_type expected_info_q[$];

   function automatic int unsigned days_in_month(input int unsigned m, input int unsigned leap_yr);
      int unsigned n;
      case (m)
         1, 3, 5, 7, 8, 10, 12: n = 31;
         4, 6, 9, 11: n = 30;
         2: n = 28 + leap_yr;
         default: n = 0;
      endcase
      return n;
   endfunction

   function automatic date_info_type calc_date_info(input logic [DayWidth-1:0] d,
                                                    input logic [MonthWidth-1:0] m,
                                                    input logic [YearWidth-1:0] y);
      int unsigned dd, mm, yy, leap_yr, len, doy, zm, zy, h;
      date_info_type info;
      dd = d;
      mm = m;
      yy = y;
      leap_yr = ((yy % 4 == 0 && yy % 100 != 0) || yy % 400 == 0) ? 1 : 0;
      len = days_in_month(mm, leap_yr);
      info = '0;
      info.leap = leap_yr[0];
      if (len != 0 && dd >= 1 && dd <= len && yy > 0) begin
         doy = dd;
         for (int i = 1; i < mm; i++) doy += days_in_month(i, leap_yr);
         // zeller: jan and feb count as months 13 and 14 of the year before
         zm = mm;
         zy = yy;
         if (mm <= 2) begin
            zm = mm + 12;
            zy = yy - 1;
         end
         h = dd + (13 * (zm + 1)) / 5 + zy + zy / 4 - zy / 100 + zy / 400;
         info.valid_res = 1'b1;
         info.day_of_year = doy[DoyWidth-1:0];
         info.weekday = WeekdayWidth'((h + 6) % 7);
         info.week_number = WeekWidth'(doy / 7 + 1);
      end
      return info;
   endfunction

   task automatic check_field(input string name, input int unsigned exp_v,
                              input int unsigned act_v);
      if (exp_v != act_v) begin
         $display("%0t ns: %s expected %0d actual %0d", $time, name, exp_v, act_v);
         mismatches++;
      end
   endtask

   initial begin
      mismatches = 0;
      good_dates = 0;
      outstanding = 0;
   end

   always @(posedge clock) begin
      date_info_type exp_info;
      if (!reset) begin
         if (req_mon.valid && req_mon.ready) begin
            exp_info = calc_date_info(req_mon.day, req_mon.month, req_mon.year);
            expected_info_q.push_back(exp_info);
            if (exp_info.valid_res) good_dates++;
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (expected_info_q.size() == 0) begin
               $display("%0t ns: result expected none actual day_of_year %0d weekday %0d",
                        $time, rsp_mon.day_of_year, rsp_mon.weekday);
               mismatches++;
            end else begin
               exp_info = expected_info_q.pop_front();
               check_field("valid_res", exp_info.valid_res, rsp_mon.valid_res);
               check_field("leap", exp_info.leap, rsp_mon.leap);
               check_field("day_of_year", exp_info.day_of_year, rsp_mon.day_of_year);
               check_field("weekday", exp_info.weekday, rsp_mon.weekday);
               check_field("week_number", exp_info.week_number, rsp_mon.week_number);
            end
         end
      end
      outstanding <= expected_info_q.size();
   end

endmodule

>>> bench/tb_top.sv
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import cdi_pkg::*;

   localparam int WatchdogLimit = 600;
   localparam int LongHoldCycles = 40;
   localparam int RandomDates = 528;

   logic clock = 1'b0;
   logic reset = 1'b1;
   int   mismatches, outstanding, good_dates;
   int   dates_sent = 0;
   int   quiet_cycles = 0;
   bit   gaps_on = 1'b1;
   bit   tail_quiet = 1'b0;
   bit   hold_request = 1'b0;

   cdi_req_if req_chan ();
   cdi_rsp_if rsp_chan ();

   calendar_date_info_core DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   date_info_checker checker_i (
      .clock       (clock),
      .reset       (reset),
      .req_mon     (req_chan),
      .rsp_mon     (rsp_chan),
      .mismatches  (mismatches),
      .outstanding (outstanding),
      .good_dates  (good_dates)
   );

   always #5ns clock = ~clock;

   initial begin
      reset <= 1'b1;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
   end

   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WatchdogLimit) begin
         $display("calendar_date_info_core: mismatch");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic send_date(input logic [DayWidth-1:0] d, input logic [MonthWidth-1:0] m,
                            input logic [YearWidth-1:0] y);
      req_chan.valid <= 1'b1;
      req_chan.day   <= d;
      req_chan.month <= m;
      req_chan.year  <= y;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      dates_sent++;
      if (!tail_quiet && gaps_on && $urandom_range(0, 3) == 0) begin
         req_chan.valid <= 1'b0;
         repeat ($urandom_range(1, 7)) @(posedge clock);
      end
   endtask

   // output side: random stalls, one long hold to back the pipeline up
   initial begin
      bit stalls_on;
      stalls_on = 1'b1;
      rsp_chan.ready <= 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         if ($urandom_range(0, 49) == 0) stalls_on = !stalls_on;
         if (hold_request) begin
            hold_request = 1'b0;
            rsp_chan.ready <= 1'b0;
            repeat (LongHoldCycles) @(posedge clock);
         end else if (!tail_quiet && stalls_on && $urandom_range(0, 4) == 0) begin
            rsp_chan.ready <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clock);
         end else begin
            rsp_chan.ready <= 1'b1;
            @(posedge clock);
         end
      end
   end

   initial begin
      logic [DayWidth-1:0]   d;
      logic [MonthWidth-1:0] m;
      logic [YearWidth-1:0]  y;
      int unsigned           pick;
      req_chan.valid <= 1'b0;
      req_chan.day   <= '0;
      req_chan.month <= '0;
      req_chan.year  <= '0;
      do @(posedge clock); while (reset);

      // field extremes, leap rules, month codes out of range
      send_date(5'd1, 4'd1, 14'd1);
      send_date(5'd31, 4'd12, 14'd9999);
      send_date(5'd29, 4'd2, 14'd2000);
      send_date(5'd29, 4'd2, 14'd1900);
      send_date(5'd29, 4'd2, 14'd2024);
      send_date(5'd29, 4'd2, 14'd2023);
      send_date(5'd28, 4'd2, 14'd2023);
      send_date(5'd31, 4'd4, 14'd2021);
      send_date(5'd30, 4'd4, 14'd2021);
      send_date(5'd0, 4'd5, 14'd2020);
      send_date(5'd31, 4'd13, 14'd2020);
      send_date(5'd15, 4'd0, 14'd2020);
      send_date(5'd15, 4'd15, 14'd2020);
      send_date(5'd10, 4'd6, 14'd0);
      send_date(5'd0, 4'd0, 14'd0);
      send_date(5'd31, 4'd12, 14'd2024);
      send_date(5'd1, 4'd3, 14'd2024);
      send_date(5'd1, 4'd1, 14'd2000);
      send_date(5'd31, 4'd1, 14'd16383);
      send_date(5'd31, 4'd2, 14'd2020);
      send_date(5'd14, 4'd3, 14'd1879);
      send_date(5'd31, 4'd7, 14'd10000);

      for (int n = 0; n < RandomDates; n++) begin
         if (n % 60 == 0) gaps_on = ($urandom_range(0, 2) != 0);
         if (n == 200) hold_request = 1'b1;
         if (n >= 470) tail_quiet = 1'b1;
         pick = $urandom_range(0, 99);
         if (pick < 15) begin
            d = DayWidth'($urandom_range(0, 31));
            m = MonthWidth'($urandom_range(0, 15));
            y = ($urandom_range(0, 7) == 0) ? '0 : YearWidth'($urandom_range(0, 16383));
         end else begin
            m = MonthWidth'($urandom_range(1, 12));
            d = ($urandom_range(0, 3) == 0) ? DayWidth'($urandom_range(28, 31)) :
                                              DayWidth'($urandom_range(1, 28));
            pick = $urandom_range(0, 19);
            if (pick < 11) y = YearWidth'($urandom_range(1, 9999));
            else if (pick < 15) y = YearWidth'($urandom_range(1, 99) * 100);
            else if (pick < 19) y = YearWidth'($urandom_range(1900, 2100));
            else y = YearWidth'($urandom_range(10000, 16383));
         end
         send_date(d, m, y);
      end
      req_chan.valid <= 1'b0;

      do @(posedge clock); while (outstanding != 0);
      repeat (10) @(posedge clock);

      $display("covered %0d dates, %0d of them real, all month codes, century and leap years",
               dates_sent, good_dates);
      $display("with random gaps on both sides and one long output hold");
      if (mismatches == 0) begin
         $display("calendar_date_info_core: match");
      end else begin
         $display("calendar_date_info_core: mismatch");
      end
      $finish;
   end

endmodule
